// File: src/tdcf_pkg.sv
// ----------------------------------------------------------------------------
// tdcf_pkg
// Types and constants shared by the timed duplicate command filter.
// ----------------------------------------------------------------------------
package tdcf_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 16;
   localparam logic [15:0] WINDOW_RESET    = 16'd1000;

   localparam logic [1:0] ACT_EXPIRE = 2'd0;
   localparam logic [1:0] ACT_CHECK  = 2'd1;
   localparam logic [1:0] ACT_RECORD = 2'd2;

   localparam logic [1:0] KIND_SELF   = 2'd0;
   localparam logic [1:0] KIND_TARGET = 2'd1;
   localparam logic [1:0] KIND_POS    = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [1:0]  kind;
      logic [7:0]  skill_slot;
      logic [15:0] server_target;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic       allowed;
      logic       stored;
      logic       table_full;
      logic [4:0] entries_in_use;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  slot;
      logic [15:0] target;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic match;
      logic aged;
   } cmp_res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RECORD,
      ST_RESP
   } state_type;

endpackage

// File: src/tdcf_cmp_unit.sv
// ----------------------------------------------------------------------------
// tdcf_cmp_unit
// Shared compare unit: request/entry match and age-versus-window test.
// ----------------------------------------------------------------------------
module tdcf_cmp_unit (
   input  tdcf_pkg::req_type     req,
   input  tdcf_pkg::entry_type   entry,
   input  logic [15:0]           window,
   output tdcf_pkg::cmp_res_type res
);
   import tdcf_pkg::*;

   logic [31:0] age;
   logic        key_eq;

   assign age    = req.now_ms - entry.stamp;
   assign key_eq = (entry.kind == req.kind) && (entry.slot == req.skill_slot);

   always_comb begin
      res.aged = age > {16'd0, window};
      case (req.kind)
         KIND_SELF:   res.match = key_eq;
         KIND_TARGET: res.match = key_eq && (entry.target == req.server_target);
         KIND_POS:    res.match = key_eq && (entry.x == req.pos_x) &&
                                  (entry.y == req.pos_y) && (entry.z == req.pos_z);
         default:     res.match = 1'b0;
      endcase
   end

endmodule

// File: src/tdcf_entry_mem.sv
// ----------------------------------------------------------------------------
// tdcf_entry_mem
// Entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tdcf_entry_mem #(
   parameter int unsigned DEPTH  = tdcf_pkg::TABLE_DEPTH_DEF,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  tdcf_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output tdcf_pkg::entry_type rd_data
);
   import tdcf_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/timed_duplicate_command_filter.sv
// ----------------------------------------------------------------------------
// timed_duplicate_command_filter
// Table of recent requests with expire, duplicate check and record actions.
//
// Usage: present a transaction on req_data and raise start while busy is low.
// busy rises on the next cycle and stays high until the result is given.
// The result appears on rsp_data for exactly one cycle with rsp_valid high;
// the receiver must take it then, there is no back-pressure.
// Steps from start to rsp_valid, D = TABLE_DEPTH:
//   expire        scans all D entries, one entry read and aged per cycle
//   check         scans up to all D entries, stopping at the first match
//   record        walks from entry 0 to the lowest free entry, writes it if any
//   unknown code  goes straight to the result
// A new transaction is taken only once the last result is given; the single
// read port of the entry store and the shared compare unit set this limit.
// csr_we writes the expiry window in ms; write only while busy is low.
// Reset clears all valid bits and the count and sets the window to 1000 ms; the
// entry store itself is not cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module timed_duplicate_command_filter #(
   parameter int unsigned TABLE_DEPTH = tdcf_pkg::TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tdcf_pkg::req_type req_data,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata,
   output logic              rsp_valid,
   output tdcf_pkg::rsp_type rsp_data
);
   import tdcf_pkg::*;

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [15:0]      window_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             issue_on_ff, issue_on_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic             allowed_ff, allowed_in;
   logic             stored_ff, stored_in;
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic             valid_clr, valid_set;
   logic [IDX_W-1:0] valid_idx;
   logic             rd_en;
   entry_type        rd_entry, wr_entry;
   cmp_res_type      cmp_res;
   logic [CNT_W+4:0] cnt_ext;
   logic             accept;

   assign accept = start && !busy;
   assign busy   = state_ff != ST_IDLE;

   assign wr_entry.kind   = req_ff.kind;
   assign wr_entry.slot   = req_ff.skill_slot;
   assign wr_entry.target = req_ff.server_target;
   assign wr_entry.x      = req_ff.pos_x;
   assign wr_entry.y      = req_ff.pos_y;
   assign wr_entry.z      = req_ff.pos_z;
   assign wr_entry.stamp  = req_ff.now_ms;

   tdcf_entry_mem #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (valid_set),
      .wr_addr (idx_ff),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_entry)
   );

   tdcf_cmp_unit u_cmp (
      .req    (req_ff),
      .entry  (rd_entry),
      .window (window_ff),
      .res    (cmp_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         window_ff   <= WINDOW_RESET;
         valid_ff    <= '0;
         cnt_ff      <= '0;
         issue_on_ff <= 1'b0;
         pend_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         issue_on_ff <= issue_on_in;
         pend_ff     <= pend_in;
         if (csr_we) begin
            window_ff <= csr_wdata;
         end
         if (valid_clr) begin
            valid_ff[valid_idx] <= 1'b0;
            cnt_ff              <= cnt_ff - CNT_W'(1);
         end else if (valid_set) begin
            valid_ff[valid_idx] <= 1'b1;
            cnt_ff              <= cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      allowed_ff  <= allowed_in;
      stored_ff   <= stored_in;
   end

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      idx_in      = idx_ff;
      issue_on_in = issue_on_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      allowed_in  = allowed_ff;
      stored_in   = stored_ff;
      valid_clr   = 1'b0;
      valid_set   = 1'b0;
      valid_idx   = pend_idx_ff;
      rd_en       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in      = req_data;
               idx_in      = '0;
               issue_on_in = 1'b1;
               allowed_in  = 1'b0;
               stored_in   = 1'b0;
               case (req_data.action)
                  ACT_EXPIRE: state_in = ST_SCAN;
                  ACT_CHECK: begin
                     allowed_in = 1'b1;
                     if (req_data.kind inside {KIND_SELF, KIND_TARGET, KIND_POS}) begin
                        state_in = ST_SCAN;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  ACT_RECORD: begin
                     if (req_data.kind inside {KIND_SELF, KIND_TARGET, KIND_POS}) begin
                        state_in = ST_RECORD;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_SCAN: begin
            rd_en       = issue_on_ff;
            pend_in     = issue_on_ff;
            pend_idx_in = idx_ff;
            if (issue_on_ff) begin
               idx_in = idx_ff + IDX_W'(1);
               if (idx_ff == LAST_IDX) begin
                  issue_on_in = 1'b0;
               end
            end
            if (pend_ff) begin
               if (req_ff.action == ACT_EXPIRE) begin
                  valid_clr = valid_ff[pend_idx_ff] && cmp_res.aged;
               end else if (valid_ff[pend_idx_ff] && cmp_res.match) begin
                  allowed_in = 1'b0;
                  state_in   = ST_RESP;
               end
               if (pend_idx_ff == LAST_IDX) begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_RECORD: begin
            valid_idx = idx_ff;
            if (!valid_ff[idx_ff]) begin
               valid_set = 1'b1;
               stored_in = 1'b1;
               state_in  = ST_RESP;
            end else if (idx_ff == LAST_IDX) begin
               state_in = ST_RESP;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_RESP: begin
            state_in    = ST_IDLE;
            issue_on_in = 1'b0;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign cnt_ext                 = {5'd0, cnt_ff};
   assign rsp_valid               = state_ff == ST_RESP;
   assign rsp_data.allowed        = allowed_ff;
   assign rsp_data.stored         = stored_ff;
   assign rsp_data.table_full     = cnt_ff == FULL_CNT;
   assign rsp_data.entries_in_use = cnt_ext[4:0];

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("transaction accepted but block not busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("entry count above table depth");

   a_count_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(cnt_ff))
      else $error("entry count out of step with valid bits");

   a_record_free_slot: assert property (@(posedge clock) disable iff (reset)
      valid_set |-> !valid_ff[idx_ff])
      else $error("record overwrote a valid entry");

endmodule
